[sv/ppu_scroll_address_unit_assert.svh]
`ifndef PPU_SCROLL_ADDRESS_UNIT_ASSERT_SVH
`define PPU_SCROLL_ADDRESS_UNIT_ASSERT_SVH

// condition must hold in the same cycle
`define PSAU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scroll unit check failed");

// condition must hold in the next cycle
`define PSAU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scroll unit check failed");

`endif

[sv/psau_pkg.sv]
package psau_pkg;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_DOT   = 2'd2;

  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_MASK   = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR   = 3'd6;
  localparam logic [2:0] REG_DATA   = 3'd7;

  localparam logic [8:0] VISIBLE_LINES = 9'd240;
  localparam logic [8:0] PRE_LINE_NTSC = 9'd261;
  localparam logic [8:0] PRE_LINE_PAL  = 9'd311;

  localparam logic [8:0] DOT_LAST_VIS   = 9'd256;
  localparam logic [8:0] DOT_HORI_COPY  = 9'd257;
  localparam logic [8:0] DOT_VERT_FIRST = 9'd280;
  localparam logic [8:0] DOT_VERT_LAST  = 9'd304;
  localparam logic [8:0] DOT_PREF_FIRST = 9'd321;
  localparam logic [8:0] DOT_PREF_LAST  = 9'd336;

  localparam logic [14:0] HORI_MASK = 15'h041F;
  localparam logic [14:0] VERT_MASK = 15'h7BE0;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] reg_index;
    logic [7:0] value;
    logic [8:0] scanline;
    logic [8:0] dot;
  } in_item_t;

  typedef struct packed {
    logic [14:0] vram_addr;
    logic [14:0] temp_addr;
    logic [2:0]  fine_scroll_x;
    logic        write_toggle;
    logic [13:0] tile_fetch_addr;
    logic [13:0] attr_fetch_addr;
  } out_item_t;

  typedef struct packed {
    logic [14:0] cur_addr;
    logic [14:0] tmp_addr;
    logic [2:0]  fine_x;
    logic        toggle;
    logic        step_by_row;
    logic        render_on;
    logic [8:0]  line_now;
  } state_t;

endpackage

[sv/ppu_scroll_address_unit.sv]
// a beat moves from the input register into the result register, raising out_valid
// throughput: one beat per cycle while the result side is not stalled; the input
//   register feeds the address logic and the result register, and the scroll state
//   updates as each beat moves into the result
// reset: synchronous on rst_n low, clears all address state, toggle and pal_timing
module ppu_scroll_address_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  psau_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output psau_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  logic                in_valid_r;
  psau_pkg::in_item_t  in_data_r;
  logic                out_valid_r;
  psau_pkg::out_item_t out_data_r;
  psau_pkg::state_t    st_r;
  psau_pkg::state_t    st_nxt;
  psau_pkg::out_item_t res;
  logic                pal_timing_r;
  logic                advance;
  logic                take_in;

  // the result register frees up when empty or drained this cycle
  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = in_valid_r && !advance;
  assign take_in   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  psau_step u_step (
    .st         (st_r),
    .item       (in_data_r),
    .pal_timing (pal_timing_r),
    .st_nxt     (st_nxt),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      st_r         <= '0;
      pal_timing_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        pal_timing_r <= cfg_data;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
        if (in_valid_r) begin
          st_r <= st_nxt;
        end
      end
      if (advance || !in_valid_r) begin
        in_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      in_data_r <= in_data;
    end
    if (advance && in_valid_r) begin
      out_data_r <= res;
    end
  end

endmodule

[sv/psau_step.sv]
module psau_step (
  input  psau_pkg::state_t    st,
  input  psau_pkg::in_item_t  item,
  input  logic                pal_timing,
  output psau_pkg::state_t    st_nxt,
  output psau_pkg::out_item_t res
);

  function automatic logic [14:0] step_x(input logic [14:0] a);
    logic [14:0] r;
    r = a;
    if (a[4:0] == 5'd31) begin
      r[4:0] = 5'd0;
      r[10]  = ~a[10];
    end else begin
      r[4:0] = a[4:0] + 5'd1;
    end
    return r;
  endfunction

  function automatic logic [14:0] step_y(input logic [14:0] a);
    logic [14:0] r;
    logic [4:0]  cy;
    r  = a;
    cy = a[9:5];
    if (a[14:12] != 3'b111) begin
      r[14:12] = a[14:12] + 3'd1;
    end else begin
      r[14:12] = 3'd0;
      if (cy == 5'd29) begin
        cy    = 5'd0;
        r[11] = ~a[11];
      end else if (cy == 5'd31) begin
        cy = 5'd0;
      end else begin
        cy = cy + 5'd1;
      end
      r[9:5] = cy;
    end
    return r;
  endfunction

  logic [8:0]  pre_line;
  logic        data_active;
  logic        dot_active;
  logic [14:0] data_addr;
  logic        fetch_dot;
  logic [14:0] cur;
  logic [14:0] dot_addr;

  assign pre_line    = pal_timing ? psau_pkg::PRE_LINE_PAL : psau_pkg::PRE_LINE_NTSC;
  assign data_active = st.render_on &&
                       (st.line_now < psau_pkg::VISIBLE_LINES || st.line_now == pre_line);
  assign dot_active  = st.render_on &&
                       (item.scanline < psau_pkg::VISIBLE_LINES || item.scanline == pre_line);

  // data port step: scroll increments while rendering on a visible or pre-render line, plain add otherwise
  always_comb begin
    if (data_active) begin
      data_addr = step_x(step_y(st.cur_addr));
    end else begin
      data_addr = st.cur_addr + (st.step_by_row ? 15'd32 : 15'd1);
    end
  end

  // fetch dots: every 8th dot of the visible span and the two prefetch tiles
  assign fetch_dot = (item.dot[2:0] == 3'd0) &&
                     ((item.dot != 9'd0 && item.dot <= psau_pkg::DOT_LAST_VIS) ||
                      (item.dot >= psau_pkg::DOT_PREF_FIRST &&
                       item.dot <= psau_pkg::DOT_PREF_LAST));

  always_comb begin
    cur = st.cur_addr;
    if (fetch_dot) begin
      if (item.dot == psau_pkg::DOT_LAST_VIS) begin
        cur = step_x(step_y(st.cur_addr));
      end else begin
        cur = step_x(st.cur_addr);
      end
    end
    if (item.dot == psau_pkg::DOT_HORI_COPY) begin
      cur = (cur & ~psau_pkg::HORI_MASK) | (st.tmp_addr & psau_pkg::HORI_MASK);
    end
    if (item.dot >= psau_pkg::DOT_VERT_FIRST && item.dot <= psau_pkg::DOT_VERT_LAST &&
        item.scanline == pre_line) begin
      cur = (cur & ~psau_pkg::VERT_MASK) | (st.tmp_addr & psau_pkg::VERT_MASK);
    end
    dot_addr = dot_active ? cur : st.cur_addr;
  end

  always_comb begin
    st_nxt = st;
    case (item.kind)
      psau_pkg::KIND_WRITE: begin
        case (item.reg_index)
          psau_pkg::REG_CTRL: begin
            st_nxt.tmp_addr[11:10] = item.value[1:0];
            st_nxt.step_by_row     = item.value[2];
          end
          psau_pkg::REG_MASK: begin
            st_nxt.render_on = item.value[3] | item.value[4];
          end
          psau_pkg::REG_SCROLL: begin
            if (!st.toggle) begin
              st_nxt.tmp_addr[4:0] = item.value[7:3];
              st_nxt.fine_x        = item.value[2:0];
              st_nxt.toggle        = 1'b1;
            end else begin
              st_nxt.tmp_addr[14:12] = item.value[2:0];
              st_nxt.tmp_addr[9:5]   = item.value[7:3];
              st_nxt.toggle          = 1'b0;
            end
          end
          psau_pkg::REG_ADDR: begin
            if (!st.toggle) begin
              st_nxt.tmp_addr[14]   = 1'b0;
              st_nxt.tmp_addr[13:8] = item.value[5:0];
              st_nxt.toggle         = 1'b1;
            end else begin
              st_nxt.tmp_addr[7:0] = item.value;
              st_nxt.cur_addr      = {st.tmp_addr[14:8], item.value};
              st_nxt.toggle        = 1'b0;
            end
          end
          psau_pkg::REG_DATA: begin
            st_nxt.cur_addr = data_addr;
          end
          default: begin
          end
        endcase
      end
      psau_pkg::KIND_READ: begin
        case (item.reg_index)
          psau_pkg::REG_STATUS: st_nxt.toggle   = 1'b0;
          psau_pkg::REG_DATA:   st_nxt.cur_addr = data_addr;
          default: begin
          end
        endcase
      end
      psau_pkg::KIND_DOT: begin
        st_nxt.line_now = item.scanline;
        st_nxt.cur_addr = dot_addr;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.vram_addr       = st_nxt.cur_addr;
    res.temp_addr       = st_nxt.tmp_addr;
    res.fine_scroll_x   = st_nxt.fine_x;
    res.write_toggle    = st_nxt.toggle;
    res.tile_fetch_addr = {2'b10, st_nxt.cur_addr[11:0]};
    res.attr_fetch_addr = {2'b10, st_nxt.cur_addr[11:10], 4'b1111,
                           st_nxt.cur_addr[9:7], st_nxt.cur_addr[4:2]};
  end

endmodule

[sv/psau_checker.sv]
`include "ppu_scroll_address_unit_assert.svh"

module psau_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input psau_pkg::out_item_t out_data
);

  logic tile_ok;
  logic attr_ok;

  assign tile_ok = out_data.tile_fetch_addr[13:12] == 2'b10 &&
                   out_data.tile_fetch_addr[11:0] == out_data.vram_addr[11:0];
  assign attr_ok = out_data.attr_fetch_addr[11:10] == out_data.vram_addr[11:10] &&
                   out_data.attr_fetch_addr[5:3] == out_data.vram_addr[9:7] &&
                   out_data.attr_fetch_addr[2:0] == out_data.vram_addr[4:2] &&
                   out_data.attr_fetch_addr[9:6] == 4'b1111;

  // a held result beat stays put
  `PSAU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // with no result beat waiting, the input does not stall
  `PSAU_ASSERT_NOW(a_no_stall_when_empty, !out_valid, !in_stall)

  // nametable fetch follows the reported address
  `PSAU_ASSERT_NOW(a_tile_addr, out_valid, tile_ok)

  // attribute fetch takes nametable and coarse x/y bits of the address
  `PSAU_ASSERT_NOW(a_attr_addr, out_valid, attr_ok)

endmodule

bind ppu_scroll_address_unit psau_checker u_psau_checker (.*);

[dv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_SPARE    = 2'd3;
  localparam logic [2:0] REG_UNUSED    = 3'd3;
  localparam logic [4:0] ROW_LAST_TILE = 5'd29;
  localparam logic [4:0] ROW_MAX       = 5'd31;
  localparam int RANDOM_ITEMS = 1400;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic                given;
    psau_pkg::out_item_t want;
  } typed_exp_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  psau_pkg::in_item_t  in_data   = '0;
  logic                out_stall = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_data  = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic                cfg_ready;
  psau_pkg::out_item_t out_data;

  ppu_scroll_address_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // scroll state as the block should hold it
  logic [14:0] v_addr     = '0;
  logic [14:0] t_addr     = '0;
  logic [2:0]  fine_x     = '0;
  logic        wr_second  = 1'b0;
  logic        inc_by_row = 1'b0;
  logic        rendering  = 1'b0;
  logic [8:0]  last_line  = '0;
  logic        pal_mode   = 1'b0;

  psau_pkg::out_item_t pending_addr_state[$];
  typed_exp_t          typed_q[$];
  psau_pkg::in_item_t  dir_items[$];
  logic                dir_given[$];
  psau_pkg::out_item_t dir_want[$];

  int fail_count = 0;
  int sent_count = 0;
  int gap_pct    = 0;
  int stall_pct  = 0;
  int hold_left  = 0;
  logic hold_req = 1'b0;

  function automatic logic [8:0] prerender_line();
    return pal_mode ? psau_pkg::PRE_LINE_PAL : psau_pkg::PRE_LINE_NTSC;
  endfunction

  function automatic logic fetch_line(logic [8:0] l);
    return (l < psau_pkg::VISIBLE_LINES) || (l == prerender_line());
  endfunction

  function automatic void coarse_x_inc();
    if (v_addr[4:0] == 5'd31) begin
      v_addr[4:0] = 5'd0;
      v_addr[10] = ~v_addr[10];
    end else begin
      v_addr = v_addr + 15'd1;
    end
  endfunction

  function automatic void fine_y_inc();
    logic [4:0] row;
    if (v_addr[14:12] != 3'd7) begin
      v_addr[14:12] = v_addr[14:12] + 3'd1;
    end else begin
      v_addr[14:12] = 3'd0;
      row = v_addr[9:5];
      if (row == ROW_LAST_TILE) begin
        row = 5'd0;
        v_addr[11] = ~v_addr[11];
      end else if (row == ROW_MAX) begin
        row = 5'd0;
      end else begin
        row = row + 5'd1;
      end
      v_addr[9:5] = row;
    end
  endfunction

  // data port access: render-time steps on fetch lines, plain increment otherwise
  function automatic void data_port_step();
    if (fetch_line(last_line) && rendering) begin
      fine_y_inc();
      coarse_x_inc();
    end else begin
      v_addr = v_addr + (inc_by_row ? 15'd32 : 15'd1);
    end
  endfunction

  function automatic psau_pkg::out_item_t predict_scroll_state(psau_pkg::in_item_t it);
    psau_pkg::out_item_t r;
    case (it.kind)
      psau_pkg::KIND_WRITE: begin
        case (it.reg_index)
          psau_pkg::REG_CTRL: begin
            t_addr[11:10] = it.value[1:0];
            inc_by_row = it.value[2];
          end
          psau_pkg::REG_MASK: rendering = it.value[3] | it.value[4];
          psau_pkg::REG_SCROLL: begin
            if (!wr_second) begin
              t_addr[4:0] = it.value[7:3];
              fine_x = it.value[2:0];
            end else begin
              t_addr[14:12] = it.value[2:0];
              t_addr[9:5] = it.value[7:3];
            end
            wr_second = ~wr_second;
          end
          psau_pkg::REG_ADDR: begin
            if (!wr_second) begin
              t_addr[14] = 1'b0;
              t_addr[13:8] = it.value[5:0];
            end else begin
              t_addr[7:0] = it.value;
              v_addr = t_addr;
            end
            wr_second = ~wr_second;
          end
          psau_pkg::REG_DATA: data_port_step();
          default: ;
        endcase
      end
      psau_pkg::KIND_READ: begin
        if (it.reg_index == psau_pkg::REG_STATUS) wr_second = 1'b0;
        else if (it.reg_index == psau_pkg::REG_DATA) data_port_step();
      end
      psau_pkg::KIND_DOT: begin
        last_line = it.scanline;
        if (fetch_line(it.scanline) && rendering) begin
          if (((it.dot >= 9'd1 && it.dot <= psau_pkg::DOT_LAST_VIS) ||
               (it.dot >= psau_pkg::DOT_PREF_FIRST && it.dot <= psau_pkg::DOT_PREF_LAST)) &&
              it.dot[2:0] == 3'd0) begin
            if (it.dot == psau_pkg::DOT_LAST_VIS) fine_y_inc();
            coarse_x_inc();
          end
          if (it.dot == psau_pkg::DOT_HORI_COPY)
            v_addr = (v_addr & ~psau_pkg::HORI_MASK) | (t_addr & psau_pkg::HORI_MASK);
          if (it.dot >= psau_pkg::DOT_VERT_FIRST && it.dot <= psau_pkg::DOT_VERT_LAST &&
              it.scanline == prerender_line())
            v_addr = (v_addr & ~psau_pkg::VERT_MASK) | (t_addr & psau_pkg::VERT_MASK);
        end
      end
      default: ;
    endcase
    r.vram_addr = v_addr;
    r.temp_addr = t_addr;
    r.fine_scroll_x = fine_x;
    r.write_toggle = wr_second;
    r.tile_fetch_addr = {2'b10, v_addr[11:0]};
    r.attr_fetch_addr = 14'h23C0 | {2'b00, v_addr[11:10], 10'd0} |
                        {8'd0, v_addr[9:7], 3'd0} | {11'd0, v_addr[4:2]};
    return r;
  endfunction

  function automatic psau_pkg::in_item_t mk_item(logic [1:0] k, logic [2:0] r,
                                                 logic [7:0] v, logic [8:0] l,
                                                 logic [8:0] d);
    return {k, r, v, l, d};
  endfunction

  function automatic void check_field(string fname, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t %s mismatch: expected %h actual %h", $time, fname, want, got);
    end
  endfunction

  task automatic add_row(psau_pkg::in_item_t it, logic given, psau_pkg::out_item_t want);
    dir_items.push_back(it);
    dir_given.push_back(given);
    dir_want.push_back(want);
  endtask

  task automatic send_beat(psau_pkg::in_item_t it, logic given, psau_pkg::out_item_t want);
    typed_q.push_back({given, want});
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.kind != KIND_SPARE) sent_count++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_addr_state.size() != 0) @(posedge clk);
  endtask

  task automatic set_pal(logic mode);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pal_mode = mode;
  endtask

  // result side stall, with an occasional long hold
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    psau_pkg::out_item_t want;
    psau_pkg::out_item_t pred;
    typed_exp_t          tx;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_addr_state.size() == 0) begin
        fail_count++;
        $display("%0t unexpected beat: expected none actual %h", $time, out_data);
      end else begin
        want = pending_addr_state.pop_front();
        check_field("vram_addr", 16'(want.vram_addr), 16'(out_data.vram_addr));
        check_field("temp_addr", 16'(want.temp_addr), 16'(out_data.temp_addr));
        check_field("fine_scroll_x", 16'(want.fine_scroll_x),
                    16'(out_data.fine_scroll_x));
        check_field("write_toggle", 16'(want.write_toggle), 16'(out_data.write_toggle));
        check_field("tile_fetch_addr", 16'(want.tile_fetch_addr),
                    16'(out_data.tile_fetch_addr));
        check_field("attr_fetch_addr", 16'(want.attr_fetch_addr),
                    16'(out_data.attr_fetch_addr));
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      pred = predict_scroll_state(in_data);
      tx = typed_q.pop_front();
      pending_addr_state.push_back(tx.given ? tx.want : pred);
    end
  end

  initial begin
    int         phase;
    int         n;
    int         pick;
    logic [8:0] line;
    logic [8:0] pre;
    logic [8:0] d;
    logic [7:0] yb;

    add_row(mk_item(psau_pkg::KIND_READ, psau_pkg::REG_STATUS, 8'h00, 9'd0, 9'd0), 1'b1,
            {15'h0000, 15'h0000, 3'd0, 1'b0, 14'h2000, 14'h23C0});
    add_row(mk_item(psau_pkg::KIND_WRITE, psau_pkg::REG_CTRL, 8'hFF, 9'd0, 9'd0), 1'b1,
            {15'h0000, 15'h0C00, 3'd0, 1'b0, 14'h2000, 14'h23C0});
    add_row(mk_item(psau_pkg::KIND_WRITE, psau_pkg::REG_SCROLL, 8'hFF, 9'd0, 9'd0), 1'b1,
            {15'h0000, 15'h0C1F, 3'd7, 1'b1, 14'h2000, 14'h23C0});
    add_row(mk_item(psau_pkg::KIND_WRITE, psau_pkg::REG_SCROLL, 8'hFF, 9'd0, 9'd0), 1'b1,
            {15'h0000, 15'h7FFF, 3'd7, 1'b0, 14'h2000, 14'h23C0});
    add_row(mk_item(psau_pkg::KIND_WRITE, psau_pkg::REG_MASK, 8'h08, 9'd0, 9'd0), 1'b0, '0);
    // vertical copy, then a y step from the bottom row past the attribute rows
    add_row(mk_item(psau_pkg::KIND_DOT, 3'd0, 8'h00, psau_pkg::PRE_LINE_NTSC,
                    psau_pkg::DOT_VERT_FIRST), 1'b0, '0);
    add_row(mk_item(psau_pkg::KIND_DOT, 3'd0, 8'h00, 9'd0, psau_pkg::DOT_LAST_VIS),
            1'b0, '0);
    add_row(mk_item(psau_pkg::KIND_DOT, 3'd0, 8'h00, 9'd0, psau_pkg::DOT_HORI_COPY),
            1'b0, '0);
    add_row(mk_item(psau_pkg::KIND_DOT, 3'd0, 8'h00, 9'd0, 9'd8), 1'b0, '0);
    add_row(mk_item(psau_pkg::KIND_DOT, 3'd0, 8'h00, 9'd0, psau_pkg::DOT_PREF_LAST),
            1'b0, '0);
    // fine y 7 on the last tile row: wraps and flips the vertical nametable
    add_row(mk_item(psau_pkg::KIND_WRITE, psau_pkg::REG_SCROLL, 8'h00, 9'd0, 9'd0), 1'b0, '0);
    add_row(mk_item(psau_pkg::KIND_WRITE, psau_pkg::REG_SCROLL, 8'hEF, 9'd0, 9'd0), 1'b0, '0);
    add_row(mk_item(psau_pkg::KIND_DOT, 3'd0, 8'h00, psau_pkg::PRE_LINE_NTSC,
                    psau_pkg::DOT_VERT_LAST), 1'b0, '0);
    add_row(mk_item(psau_pkg::KIND_DOT, 3'd0, 8'h00, 9'd0, psau_pkg::DOT_LAST_VIS),
            1'b0, '0);
    add_row(mk_item(psau_pkg::KIND_READ, psau_pkg::REG_DATA, 8'h00, 9'd0, 9'd0), 1'b0, '0);
    add_row(mk_item(psau_pkg::KIND_DOT, psau_pkg::REG_DATA, 8'hFF, 9'h1FF, 9'h1FF),
            1'b0, '0);
    add_row(mk_item(psau_pkg::KIND_WRITE, psau_pkg::REG_DATA, 8'h00, 9'd0, 9'd0), 1'b0, '0);
    add_row(mk_item(psau_pkg::KIND_WRITE, psau_pkg::REG_CTRL, 8'h00, 9'd0, 9'd0), 1'b0, '0);
    add_row(mk_item(psau_pkg::KIND_READ, psau_pkg::REG_DATA, 8'h00, 9'h1FF, 9'h1FF),
            1'b0, '0);
    add_row(mk_item(psau_pkg::KIND_WRITE, psau_pkg::REG_ADDR, 8'hFF, 9'd0, 9'd0), 1'b0, '0);
    add_row(mk_item(psau_pkg::KIND_WRITE, psau_pkg::REG_ADDR, 8'h00, 9'd0, 9'd0), 1'b0, '0);
    add_row(mk_item(psau_pkg::KIND_WRITE, REG_UNUSED, 8'hAA, 9'd0, 9'd0), 1'b0, '0);
    add_row(mk_item(psau_pkg::KIND_READ, psau_pkg::REG_CTRL, 8'h00, 9'd0, 9'd0), 1'b0, '0);
    add_row(mk_item(KIND_SPARE, psau_pkg::REG_DATA, 8'hFF, 9'h1FF, 9'h1FF), 1'b0, '0);
    add_row(mk_item(psau_pkg::KIND_WRITE, psau_pkg::REG_MASK, 8'h10, 9'd0, 9'd0), 1'b0, '0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < dir_items.size(); i++)
      send_beat(dir_items[i], dir_given[i], dir_want[i]);

    for (phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 53; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 53; end
        default: begin gap_pct = 33; stall_pct = 33; end
      endcase
      set_pal((phase % 2) == 0);

      if (phase == 0) begin
        // result side held off while beats keep coming
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
          send_beat(mk_item(psau_pkg::KIND_DOT, 3'd0, 8'h00, 9'($urandom_range(239)),
                            9'($urandom_range(1, 42) * 8)), 1'b0, '0);
      end

      while (sent_count < (phase + 1) * RANDOM_ITEMS / 4) begin
        pre = prerender_line();
        if ($urandom_range(39) == 0) drain();
        pick = $urandom_range(9);
        case (pick)
          0, 1: begin
            send_beat(mk_item(psau_pkg::KIND_READ, psau_pkg::REG_STATUS, 8'($urandom),
                              9'($urandom_range(511)), 9'($urandom_range(511))),
                      1'b0, '0);
            send_beat(mk_item(psau_pkg::KIND_WRITE, psau_pkg::REG_CTRL, 8'($urandom),
                              9'd0, 9'd0), 1'b0, '0);
            send_beat(mk_item(psau_pkg::KIND_WRITE, psau_pkg::REG_SCROLL, 8'($urandom),
                              9'd0, 9'd0), 1'b0, '0);
            yb[2:0] = ($urandom_range(1) == 1) ? 3'd7 : 3'($urandom_range(7));
            case ($urandom_range(2))
              0: yb[7:3] = ROW_LAST_TILE;
              1: yb[7:3] = ROW_MAX;
              default: yb[7:3] = 5'($urandom_range(31));
            endcase
            send_beat(mk_item(psau_pkg::KIND_WRITE, psau_pkg::REG_SCROLL, yb, 9'd0, 9'd0),
                      1'b0, '0);
            if ($urandom_range(1) == 1) begin
              send_beat(mk_item(psau_pkg::KIND_WRITE, psau_pkg::REG_ADDR, 8'($urandom),
                                9'd0, 9'd0), 1'b0, '0);
              send_beat(mk_item(psau_pkg::KIND_WRITE, psau_pkg::REG_ADDR, 8'($urandom),
                                9'd0, 9'd0), 1'b0, '0);
            end
            yb = 8'($urandom);
            yb = ($urandom_range(3) != 0) ? (yb | 8'h08) : (yb & 8'hE7);
            send_beat(mk_item(psau_pkg::KIND_WRITE, psau_pkg::REG_MASK, yb, 9'd0, 9'd0),
                      1'b0, '0);
          end
          2, 3, 4: begin
            n = $urandom_range(99);
            if (n < 55) line = 9'($urandom_range(239));
            else if (n < 80) line = pre;
            else if (n < 90) line = 9'($urandom_range(240, pre));
            else line = 9'($urandom_range(511));
            n = $urandom_range(4, 12);
            for (int i = 0; i < n; i++) begin
              case ($urandom_range(9))
                0, 1, 2, 3: d = 9'($urandom_range(1, 32) * 8);
                4: d = psau_pkg::DOT_LAST_VIS;
                5: d = psau_pkg::DOT_HORI_COPY;
                6: d = 9'($urandom_range(psau_pkg::DOT_VERT_FIRST, psau_pkg::DOT_VERT_LAST));
                7: d = ($urandom_range(1) == 1) ? psau_pkg::DOT_PREF_LAST - 9'd8 :
                                                  psau_pkg::DOT_PREF_LAST;
                8: d = 9'($urandom_range(psau_pkg::DOT_PREF_FIRST, psau_pkg::DOT_PREF_LAST));
                default: d = 9'($urandom_range(511));
              endcase
              send_beat(mk_item(psau_pkg::KIND_DOT, 3'($urandom_range(7)), 8'($urandom),
                                line, d), 1'b0, '0);
            end
          end
          5: begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
              send_beat(mk_item(($urandom_range(1) == 1) ? psau_pkg::KIND_READ :
                                                           psau_pkg::KIND_WRITE,
                                psau_pkg::REG_DATA, 8'($urandom), 9'd0, 9'd0),
                        1'b0, '0);
          end
          6: begin
            // half of a register pair, then a read or write of the status or a random register
            send_beat(mk_item(psau_pkg::KIND_WRITE,
                              ($urandom_range(1) == 1) ? psau_pkg::REG_SCROLL :
                                                         psau_pkg::REG_ADDR,
                              8'($urandom), 9'd0, 9'd0), 1'b0, '0);
            send_beat(mk_item(($urandom_range(1) == 1) ? psau_pkg::KIND_READ :
                                                         psau_pkg::KIND_WRITE,
                              ($urandom_range(1) == 1) ? psau_pkg::REG_STATUS :
                                                         3'($urandom_range(7)),
                              8'($urandom), 9'd0, 9'd0), 1'b0, '0);
          end
          7: send_beat(mk_item(2'($urandom_range(3)), 3'($urandom_range(7)), 8'($urandom),
                               9'($urandom_range(511)), 9'($urandom_range(511))), 1'b0, '0);
          8: begin
            send_beat(mk_item(psau_pkg::KIND_DOT, 3'd0, 8'h00, pre, psau_pkg::DOT_LAST_VIS),
                      1'b0, '0);
            send_beat(mk_item(psau_pkg::KIND_DOT, 3'd0, 8'h00, pre, psau_pkg::DOT_HORI_COPY),
                      1'b0, '0);
            send_beat(mk_item(psau_pkg::KIND_DOT, 3'd0, 8'h00, pre,
                              9'($urandom_range(psau_pkg::DOT_VERT_FIRST,
                                                psau_pkg::DOT_VERT_LAST))), 1'b0, '0);
            send_beat(mk_item(psau_pkg::KIND_DOT, 3'd0, 8'h00, pre,
                              psau_pkg::DOT_PREF_LAST - 9'd8), 1'b0, '0);
            send_beat(mk_item(psau_pkg::KIND_DOT, 3'd0, 8'h00, pre, psau_pkg::DOT_PREF_LAST),
                      1'b0, '0);
          end
          default: send_beat(mk_item(psau_pkg::KIND_WRITE, psau_pkg::REG_MASK, 8'($urandom),
                                     9'd0, 9'd0), 1'b0, '0);
        endcase
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_addr_state.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_top failed");
    $finish;
  end

endmodule
